>>> rtl/ecgpd_pkg.sv
package ecgpd_pkg;

    localparam int DATA_BYTES = 7;
    localparam int IDX_W      = $clog2(DATA_BYTES);
    localparam int ID_W       = 7;
    localparam int BYTE_W     = 8;
    localparam int CH_W       = 16;

    localparam logic [ID_W-1:0] PACKET_ID_RST = 7'h08;
    localparam logic [BYTE_W-2:0] LOW7_MASK  = 7'h7f;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_CHECK  = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic            emit;
        logic [CH_W-1:0] ch_a;
        logic [CH_W-1:0] ch_b;
        logic [CH_W-1:0] ch_c;
    } t_parse_out;

endpackage

>>> rtl/ecgpd_parser.sv
module ecgpd_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [ecgpd_pkg::BYTE_W-1:0] i_byte,
    input  logic [ecgpd_pkg::ID_W-1:0]   i_packet_id,
    output ecgpd_pkg::t_parse_out       o_res
);
    import ecgpd_pkg::*;

    t_phase             r_phase, n_phase, eff_phase;
    logic [BYTE_W-1:0]  r_hdr, n_hdr;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [BYTE_W-1:0]  r_rest [DATA_BYTES];
    logic               wr_en;
    logic [BYTE_W-1:0]  wr_data;

    // any byte with bit 7 clear resynchronises to idle
    always_comb begin
        eff_phase = i_byte[BYTE_W-1] ? r_phase : PH_IDLE;
    end

    always_comb begin
        n_phase = eff_phase;
        n_hdr   = r_hdr;
        n_idx   = r_idx;
        wr_en   = 1'b0;
        wr_data = {r_hdr[r_idx], i_byte[BYTE_W-2:0] & LOW7_MASK};
        o_res.emit = 1'b0;
        o_res.ch_a = {r_rest[0], r_rest[1]};
        o_res.ch_b = {r_rest[2], r_rest[3]};
        o_res.ch_c = {r_rest[4], r_rest[5]};
        unique case (eff_phase)
            PH_IDLE: begin
                if (i_byte == {1'b0, i_packet_id}) begin
                    n_phase = PH_HEADER;
                    n_hdr   = '0;
                end
            end
            PH_HEADER: begin
                n_hdr   = i_byte;
                n_idx   = '0;
                n_phase = PH_DATA;
            end
            PH_DATA: begin
                wr_en = 1'b1;
                if (r_idx == IDX_W'(DATA_BYTES - 1)) begin
                    n_idx   = '0;
                    n_phase = PH_CHECK;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            PH_CHECK: begin
                // checksum byte is swallowed unchecked
                o_res.emit = 1'b1;
                n_phase    = PH_DONE;
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hdr   <= '0;
            r_idx   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && wr_en) begin
            r_rest[r_idx] <= wr_data;
        end
    end

endmodule

>>> rtl/ecg_packet_deframer.sv
// Byte-serial deframer: one received byte per beat, sustained one beat per cycle. A byte with
// bit 7 clear resyncs and is matched against packet_id; then a header byte, seven data bytes
// (bit 7 restored from the header) and an unchecked checksum byte. One result of three 16-bit
// channels is issued per packet after the checksum beat is accepted, through an input register
// and a result register. The input side stalls only while a checksum beat sits in the input
// register and the previous result is still held by a stalled output.
module ecg_packet_deframer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rx_valid,
    output logic                          o_rx_stall,
    input  logic [ecgpd_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                          o_res_valid,
    input  logic                          i_res_stall,
    output logic [ecgpd_pkg::CH_W-1:0]    o_channel_a,
    output logic [ecgpd_pkg::CH_W-1:0]    o_channel_b,
    output logic [ecgpd_pkg::CH_W-1:0]    o_channel_c,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ecgpd_pkg::ID_W-1:0]    i_cfg_data
);
    import ecgpd_pkg::*;

    logic [ID_W-1:0]   r_packet_id;
    logic              r_rx_vld;
    logic [BYTE_W-1:0] r_rx_byte;
    logic              r_out_vld;
    logic [CH_W-1:0]   r_ch_a, r_ch_b, r_ch_c;
    t_parse_out        parse;
    logic              out_blocked;
    logic              advance;
    logic              rx_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_id <= PACKET_ID_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_packet_id <= i_cfg_data;
        end
    end

    ecgpd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_rx_byte),
        .i_packet_id (r_packet_id),
        .o_res       (parse)
    );

    // a beat that yields no result may move on even with the output held
    assign out_blocked = r_out_vld && i_res_stall;
    assign advance     = r_rx_vld && !(parse.emit && out_blocked);
    assign o_rx_stall  = r_rx_vld && !advance;
    assign rx_take     = i_rx_valid && !o_rx_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_vld <= 1'b0;
        end else if (rx_take) begin
            r_rx_vld <= 1'b1;
        end else if (advance) begin
            r_rx_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_take) begin
            r_rx_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!out_blocked) begin
            r_out_vld <= advance && parse.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && parse.emit) begin
            r_ch_a <= parse.ch_a;
            r_ch_b <= parse.ch_b;
            r_ch_c <= parse.ch_c;
        end
    end

    assign o_res_valid = r_out_vld;
    assign o_channel_a = r_ch_a;
    assign o_channel_b = r_ch_b;
    assign o_channel_c = r_ch_c;

endmodule

>>> rtl/ecg_packet_deframer_chk.sv
module ecg_packet_deframer_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rx_valid,
    input  logic                          o_rx_stall,
    input  logic [ecgpd_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic                          o_res_valid,
    input  logic                          i_res_stall,
    input  logic [ecgpd_pkg::CH_W-1:0]    o_channel_a,
    input  logic [ecgpd_pkg::CH_W-1:0]    o_channel_b,
    input  logic [ecgpd_pkg::CH_W-1:0]    o_channel_c,
    input  logic                          i_cfg_valid,
    input  logic                          o_cfg_ready,
    input  logic [ecgpd_pkg::ID_W-1:0]    i_cfg_data
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    // a held result keeps its channels
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=>
            o_res_valid && $stable(o_channel_a) && $stable(o_channel_b)
            && $stable(o_channel_c))
        else $error("held result changed");

    // input backpressure only comes from a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_res_valid && i_res_stall)
        else $error("input stalled without a held result");

endmodule

bind ecg_packet_deframer ecg_packet_deframer_chk u_chk (.*);
